@@ design/varint_zigzag_codec_assert.svh @@
// Assertion macros for the varint codec checker.
// All macros sample on aclk; the first two are masked while aresetn is low.
`ifndef VARINT_ZIGZAG_CODEC_ASSERT_SVH
`define VARINT_ZIGZAG_CODEC_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define VZC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("varint codec check failed");

// Next-cycle implication, masked during reset.
`define VZC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("varint codec check failed");

// Next-cycle implication that also covers the reset cycles.
`define VZC_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("varint codec reset check failed");

`endif

@@ design/vzc_pkg.sv @@
package vzc_pkg;

    // Opcodes of an input word
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Kinds of a result word
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam logic [63:0] MASK_NARROW = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MASK_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;

    // Group limits: 5 bytes narrow, 10 bytes wide; encode stops after 9 continuations
    localparam logic [3:0] DEC_LIMIT_NARROW = 4'd5;
    localparam logic [3:0] DEC_LIMIT_WIDE   = 4'd10;
    localparam logic [3:0] ENC_MAX_CONT     = 4'd9;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic        opcode;
        logic        wide;
        logic        zigzag;
        logic [63:0] in_value;
        logic [7:0]  in_byte;
    } in_word_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [63:0] out_value;
        logic        last;
    } out_word_t;

    // Classified command: value already masked and zigzag mapped for encode
    typedef struct packed {
        logic        opcode;
        logic        wide;
        logic        zigzag;
        logic [63:0] value;
        logic [7:0]  in_byte;
    } cmd_t;

    // Queue status: valid toward the back end, full toward the front end
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

@@ design/vzc_front.sv @@
module vzc_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  vzc_pkg::in_word_t s_data,
    input  vzc_pkg::q_status_t q_status,
    output logic              push,
    output vzc_pkg::cmd_t     cmd
);

    logic [63:0] mask;
    logic [63:0] v;
    logic        sign;
    logic [63:0] fill;

    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    // Width restriction and zigzag mapping of the encode value
    always_comb begin
        mask = s_data.wide ? vzc_pkg::MASK_WIDE : vzc_pkg::MASK_NARROW;
        v    = s_data.in_value & mask;
        sign = s_data.wide ? v[63] : v[31];
        fill = sign ? mask : 64'd0;
        cmd.opcode  = s_data.opcode;
        cmd.wide    = s_data.wide;
        cmd.zigzag  = s_data.zigzag;
        cmd.in_byte = s_data.in_byte;
        cmd.value   = s_data.zigzag ? (((v << 1) ^ fill) & mask) : v;
    end

endmodule

@@ design/vzc_queue.sv @@
module vzc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  vzc_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output vzc_pkg::q_status_t q_status,
    output vzc_pkg::cmd_t      head_cmd
);

    vzc_pkg::cmd_t                  mem_reg [vzc_pkg::Q_DEPTH];
    logic [vzc_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [vzc_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [vzc_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;

    localparam logic [vzc_pkg::Q_PTR_W-1:0] PTR_LAST = vzc_pkg::Q_PTR_W'(vzc_pkg::Q_DEPTH - 1);
    localparam logic [vzc_pkg::Q_CNT_W-1:0] CNT_FULL = vzc_pkg::Q_CNT_W'(vzc_pkg::Q_DEPTH);

    assign q_status.valid = (cnt_reg != '0);
    assign q_status.full  = (cnt_reg == CNT_FULL);
    assign head_cmd       = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/vzc_back.sv @@
module vzc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  vzc_pkg::q_status_t q_status,
    input  vzc_pkg::cmd_t      cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vzc_pkg::out_word_t m_data
);

    logic                m_valid_reg, m_valid_next;
    vzc_pkg::out_word_t  m_data_reg, m_data_next;
    logic                enc_busy_reg, enc_busy_next;
    logic [63:0]         enc_val_reg, enc_val_next;
    logic [3:0]          enc_cnt_reg, enc_cnt_next;
    logic [63:0]         acc_reg, acc_next;
    logic [3:0]          grp_reg, grp_next;
    logic                wide_lat_reg, wide_lat_next;
    logic                zz_lat_reg, zz_lat_next;

    logic        adv;
    logic        take;
    logic        do_enc;
    logic        do_dec;
    logic [63:0] src_val;
    logic [3:0]  src_cnt;
    logic        more;
    logic        first;
    logic        lat_wide;
    logic        lat_zz;
    logic [63:0] dmask;
    logic [63:0] base;
    logic [6:0]  shift_full;
    logic [5:0]  shift;
    logic [63:0] acc_new;
    logic [3:0]  grp_inc;
    logic [3:0]  limit;
    logic        done;
    logic [63:0] dval;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Output register frees up when empty or when taken
    assign adv    = !m_valid_reg || m_ready;
    assign take   = adv && !enc_busy_reg && q_status.valid;
    assign pop    = take;
    assign do_enc = adv && (enc_busy_reg || (take && cmd.opcode == vzc_pkg::OP_ENCODE));
    assign do_dec = take && (cmd.opcode == vzc_pkg::OP_DECODE);

    // Encode: one seven-bit group per cycle while the output register frees up
    always_comb begin
        src_val = enc_busy_reg ? enc_val_reg : cmd.value;
        src_cnt = enc_busy_reg ? enc_cnt_reg : 4'd0;
        more    = (src_val[63:7] != 57'd0) && (src_cnt < vzc_pkg::ENC_MAX_CONT);
    end

    // Decode: merge one group into the accumulator
    always_comb begin
        first      = (grp_reg == 4'd0);
        lat_wide   = first ? cmd.wide : wide_lat_reg;
        lat_zz     = first ? cmd.zigzag : zz_lat_reg;
        dmask      = lat_wide ? vzc_pkg::MASK_WIDE : vzc_pkg::MASK_NARROW;
        base       = first ? 64'd0 : acc_reg;
        shift_full = {3'd0, grp_reg} * 7'd7;
        shift      = shift_full[5:0];
        acc_new    = (base | ({57'd0, cmd.in_byte[6:0]} << shift)) & dmask;
        grp_inc    = grp_reg + 4'd1;
        limit      = lat_wide ? vzc_pkg::DEC_LIMIT_WIDE : vzc_pkg::DEC_LIMIT_NARROW;
        done       = !cmd.in_byte[7] || (grp_inc >= limit);
        dval       = lat_zz ? (((acc_new >> 1) ^ (acc_new[0] ? dmask : 64'd0)) & dmask)
                            : acc_new;
    end

    // Next-state selection
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        enc_busy_next = enc_busy_reg;
        enc_val_next  = enc_val_reg;
        enc_cnt_next  = enc_cnt_reg;
        acc_next      = acc_reg;
        grp_next      = grp_reg;
        wide_lat_next = wide_lat_reg;
        zz_lat_next   = zz_lat_reg;
        if (adv) begin
            m_valid_next = 1'b0;
        end
        if (do_enc) begin
            m_valid_next          = 1'b1;
            m_data_next.out_kind  = vzc_pkg::KIND_BYTE;
            m_data_next.out_byte  = more ? {1'b1, src_val[6:0]} : src_val[7:0];
            m_data_next.out_value = 64'd0;
            m_data_next.last      = !more;
            enc_busy_next         = more;
            enc_val_next          = src_val >> 7;
            enc_cnt_next          = src_cnt + 4'd1;
        end
        if (do_dec) begin
            wide_lat_next = lat_wide;
            zz_lat_next   = lat_zz;
            if (done) begin
                acc_next              = 64'd0;
                grp_next              = 4'd0;
                m_valid_next          = 1'b1;
                m_data_next.out_kind  = vzc_pkg::KIND_VALUE;
                m_data_next.out_byte  = 8'd0;
                m_data_next.out_value = dval;
                m_data_next.last      = 1'b1;
            end else begin
                acc_next = acc_new;
                grp_next = grp_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            enc_busy_reg <= 1'b0;
            acc_reg      <= 64'd0;
            grp_reg      <= 4'd0;
            wide_lat_reg <= 1'b0;
            zz_lat_reg   <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            enc_busy_reg <= enc_busy_next;
            acc_reg      <= acc_next;
            grp_reg      <= grp_next;
            wide_lat_reg <= wide_lat_next;
            zz_lat_reg   <= zz_lat_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        enc_val_reg <= enc_val_next;
        enc_cnt_reg <= enc_cnt_next;
    end

endmodule

@@ design/varint_zigzag_codec.sv @@
// Input words are registered in the queue, results in the back-end output register.
// The single back-end byte sequencer takes one decode input byte per cycle, or emits
// one encode byte per cycle, 1 to 10 bytes per value; it pauses on an output stall.
// A two-word queue between front and back keeps input taken while output stalls.
// Reset (aresetn low, synchronous) empties the queue and the output register and
// clears the decode accumulator, group count and latched width and zigzag.
module varint_zigzag_codec (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vzc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vzc_pkg::out_word_t m_data
);

    vzc_pkg::q_status_t q_status;
    vzc_pkg::cmd_t      push_cmd;
    vzc_pkg::cmd_t      head_cmd;
    logic               push;
    logic               pop;

    vzc_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    vzc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_status (q_status),
        .head_cmd (head_cmd)
    );

    vzc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .cmd      (head_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ design/vzc_checker.sv @@
`include "varint_zigzag_codec_assert.svh"

module vzc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input vzc_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input vzc_pkg::out_word_t m_data
);

    // A stalled input word holds
    `VZC_ASSERT_NEXT(a_s_hold, s_valid && !s_ready, s_valid && $stable(s_data))

    // A stalled result word holds
    `VZC_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Continuation bit is set exactly on non-final encoded bytes
    `VZC_ASSERT_NOW(a_enc_cont, m_valid && m_data.out_kind == vzc_pkg::KIND_BYTE, m_data.out_byte[7] == !m_data.last && m_data.out_value == 64'd0)

    // A decoded value is always final and carries no byte
    `VZC_ASSERT_NOW(a_dec_last, m_valid && m_data.out_kind == vzc_pkg::KIND_VALUE, m_data.last && m_data.out_byte == 8'd0)

    // Reset empties the output
    `VZC_ASSERT_RST(a_rst_empty, !aresetn, !m_valid)

endmodule

bind varint_zigzag_codec vzc_checker u_vzc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
